// ===== rtl/bbc_pkg.sv =====
// Package: shared types, codes and bracket decode functions for the bracket balance checker.
package bbc_pkg;

  // Bracket kind held in each stack cell.
  typedef enum logic [1:0] {
    KIND_PAREN = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Sticky error held for the current text.
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CLOSE = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_BALANCED = 2'd0,
    ST_BAD_CLOSE = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam int CH_W = 8;
  localparam int WHERE_W = 16;

  localparam logic [CH_W-1:0] CH_OPEN_PAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_CLOSE_PAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_OPEN_SQUARE = 8'h5B;
  localparam logic [CH_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [CH_W-1:0] CH_OPEN_CURLY = 8'h7B;
  localparam logic [CH_W-1:0] CH_CLOSE_CURLY = 8'h7D;

  // Control for one step of the cell row.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_op_t;

  function automatic kind_t open_kind(input logic [CH_W-1:0] c);
    kind_t k;
    case (c)
      CH_OPEN_PAREN: k = KIND_PAREN;
      CH_OPEN_SQUARE: k = KIND_SQUARE;
      CH_OPEN_CURLY: k = KIND_CURLY;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [CH_W-1:0] c);
    kind_t k;
    case (c)
      CH_CLOSE_PAREN: k = KIND_PAREN;
      CH_CLOSE_SQUARE: k = KIND_SQUARE;
      CH_CLOSE_CURLY: k = KIND_CURLY;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/bbc_in_if.sv =====
// Interface: input channel carrying one text byte and its last flag.
interface bbc_in_if;
  import bbc_pkg::*;

  logic valid;
  logic ready;
  logic [CH_W-1:0] ch;
  logic last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

// ===== rtl/bbc_out_if.sv =====
// Interface: result channel carrying status and offending position.
interface bbc_out_if;
  import bbc_pkg::*;

  logic valid;
  logic ready;
  logic [1:0] status;
  logic [WHERE_W-1:0] where;

  modport source (output valid, output status, output where, input ready);
  modport sink (input valid, input status, input where, output ready);
endinterface

// ===== rtl/bbc_cell.sv =====
// Module: one stack cell; shifts toward the bottom on push, toward the top on pop.
module bbc_cell (
  input logic clk,
  input bbc_pkg::cell_op_t op,
  input bbc_pkg::kind_t from_above,
  input bbc_pkg::kind_t from_below,
  output bbc_pkg::kind_t kind
);
  import bbc_pkg::*;

  always_ff @(posedge clk) begin
    if (op.push) begin
      kind <= from_above;
    end else if (op.pop) begin
      kind <= from_below;
    end
  end
endmodule

// ===== rtl/bracket_balance_checker.sv =====
// Top level: bracket balance checker built on a shifting row of stack cells.
//
//  channel  dir  fields                 meaning
//  text     in   ch[7:0], last          one byte of the text, last marks its end
//  result   out  status[1:0], where[15:0] one result per text, after the last byte
//
// One item is taken every cycle unless a waiting result stalls the input; the stack top
// always sits in cell 0, so a push or a pop is a single shift of the whole cell row.
// The result of a text appears in the output register the cycle after its last byte.
// Reset (rst, synchronous) clears the control state; cell contents need no reset since
// only cells below the stack level are ever read. A waiting result holds in the output
// register and stalls the input until the receiver takes it.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64,
  parameter longint unsigned MAX_LENGTH = 65535
) (
  input logic clk,
  input logic rst,
  bbc_in_if.sink text,
  bbc_out_if.source result
);
  import bbc_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);

  // Control state of the current text.
  logic [LVL_W-1:0] level, level_next;
  logic [CNT_W-1:0] count, count_next;
  logic [WHERE_W-1:0] bottom_pos, bottom_pos_next;
  logic [WHERE_W-1:0] error_pos, error_pos_next;
  err_t err, err_next;

  // Output register.
  logic res_valid;
  status_t res_status, res_status_next;
  logic [WHERE_W-1:0] res_where, res_where_next;

  logic accept;
  err_t err_in;
  kind_t ok, ck, top;
  logic [WHERE_W-1:0] pos;
  cell_op_t op;
  kind_t cell_kind [STACK_DEPTH];

  assign text.ready = !res_valid || result.ready;
  assign accept = text.valid && text.ready;

  assign result.valid = res_valid;
  assign result.status = res_status;
  assign result.where = res_where;

  // Cell row: cell 0 is the top of the stack.
  assign top = cell_kind[0];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t above, below;
    if (i == 0) begin : g_top
      assign above = ok;
    end else begin : g_mid
      assign above = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = cell_kind[i];
    end else begin : g_up
      assign below = cell_kind[i+1];
    end
    bbc_cell u_cell (
      .clk(clk),
      .op(op),
      .from_above(above),
      .from_below(below),
      .kind(cell_kind[i])
    );
  end

  always_comb begin
    ok = open_kind(text.ch);
    ck = close_kind(text.ch);

    // Length limit trips before this byte is looked at.
    err_in = err;
    if (err == ERR_NONE && count >= CNT_MAX) begin
      err_in = ERR_OVERFLOW;
    end
    count_next = (count < CNT_MAX) ? count + 1'b1 : count;
    pos = WHERE_W'(count_next);

    err_next = err_in;
    level_next = level;
    bottom_pos_next = bottom_pos;
    error_pos_next = error_pos;
    op = '0;

    if (err_in == ERR_NONE) begin
      if (ok != KIND_NONE) begin
        if (level == LVL_FULL) begin
          err_next = ERR_OVERFLOW;
        end else begin
          if (level == '0) begin
            bottom_pos_next = pos;
          end
          op.push = accept;
          level_next = level + 1'b1;
        end
      end else if (ck != KIND_NONE) begin
        if (level == '0 || top != ck) begin
          err_next = ERR_CLOSE;
          error_pos_next = pos;
        end else begin
          op.pop = accept;
          level_next = level - 1'b1;
        end
      end
    end

    // Form the result from the state left by this byte.
    case (err_next)
      ERR_CLOSE: begin
        res_status_next = ST_BAD_CLOSE;
        res_where_next = error_pos_next;
      end
      ERR_OVERFLOW: begin
        res_status_next = ST_OVERFLOW;
        res_where_next = '0;
      end
      default: begin
        if (level_next != '0) begin
          res_status_next = ST_UNCLOSED;
          res_where_next = bottom_pos_next;
        end else begin
          res_status_next = ST_BALANCED;
          res_where_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      count <= '0;
      bottom_pos <= '0;
      error_pos <= '0;
      err <= ERR_NONE;
      res_valid <= 1'b0;
    end else begin
      // A new result replaces the one being taken in the same cycle.
      if (accept && text.last) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        if (text.last) begin
          // Clear everything for the next text.
          level <= '0;
          count <= '0;
          bottom_pos <= '0;
          error_pos <= '0;
          err <= ERR_NONE;
        end else begin
          level <= level_next;
          count <= count_next;
          bottom_pos <= bottom_pos_next;
          error_pos <= error_pos_next;
          err <= err_next;
        end
      end
    end
  end

  // Load the result payload with the last byte of a text.
  always_ff @(posedge clk) begin
    if (accept && text.last) begin
      res_status <= res_status_next;
      res_where <= res_where_next;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_FULL) else $error("stack level beyond depth");

  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    $onehot0({op.push, op.pop})) else $error("push and pop in one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && text.last |=> res_valid) else $error("result missing after last byte");

  a_where_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_BALANCED || res_status == ST_OVERFLOW) |-> res_where == '0)
    else $error("position given for balanced or overflow result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |-> !accept) else $error("pending result overwritten");
endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the bracket balance checker: directed and random texts, self-checked.
module tb_top;
  import bbc_pkg::*;

  // The block is built with its default stack depth and length limit.
  localparam int TB_STACK_DEPTH = 64;
  localparam longint unsigned TB_MAX_LENGTH = 65535;

  // Receiver hold-off: once this many results are taken, hold ready low for a while.
  localparam int HOLD_AT = 30;
  localparam int HOLD_CYCLES = 400;

  // Result shows up the cycle after the last byte; let the bench settle before ending.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam longint RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    status_t status;
    logic [WHERE_W-1:0] where;
  } verdict_t;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic last;
    int unsigned gap;
  } text_byte_t;

  typedef enum {
    SHAPE_BALANCED,
    SHAPE_BAD_CLOSE,
    SHAPE_UNCLOSED,
    SHAPE_DEEP,
    SHAPE_NOISE
  } text_shape_t;

  logic clk;
  logic rst;

  bbc_in_if text_ch();
  bbc_out_if result_ch();

  bracket_balance_checker #(
    .STACK_DEPTH(TB_STACK_DEPTH),
    .MAX_LENGTH(TB_MAX_LENGTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .text(text_ch),
    .result(result_ch)
  );

  // Bytes waiting to be offered, each with the idle cycles to spend before it.
  text_byte_t pending_bytes[$];
  // Text under construction by the stimulus tasks.
  logic [CH_W-1:0] draft[$];
  // Verdicts predicted for texts whose last byte was taken, oldest first.
  verdict_t expected_verdicts[$];

  int unsigned queued_items = 0;
  int unsigned mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: one open text at a time.
  // ---------------------------------------------------------------------------
  kind_t open_stack[TB_STACK_DEPTH];
  int unsigned open_depth;
  longint unsigned text_len;
  longint unsigned bottom_pos;
  longint unsigned bad_pos;
  err_t text_err;

  task automatic clear_checker();
    open_depth = 0;
    text_len = 0;
    bottom_pos = 0;
    bad_pos = 0;
    text_err = ERR_NONE;
  endtask

  // Advance the predictor by one byte; on the last byte, queue the verdict and clear.
  task automatic advance_checker(input logic [CH_W-1:0] c, input logic fin);
    kind_t opened;
    kind_t closing;
    verdict_t v;
    opened = KIND_NONE;
    closing = KIND_NONE;
    case (c)
      CH_OPEN_PAREN: opened = KIND_PAREN;
      CH_OPEN_SQUARE: opened = KIND_SQUARE;
      CH_OPEN_CURLY: opened = KIND_CURLY;
      CH_CLOSE_PAREN: closing = KIND_PAREN;
      CH_CLOSE_SQUARE: closing = KIND_SQUARE;
      CH_CLOSE_CURLY: closing = KIND_CURLY;
      default: ;
    endcase

    // A byte beyond the length limit overflows the text unless an error is already held;
    // the count itself saturates at the limit.
    if (text_err == ERR_NONE && text_len >= TB_MAX_LENGTH) text_err = ERR_OVERFLOW;
    if (text_len < TB_MAX_LENGTH) text_len++;

    if (text_err == ERR_NONE) begin
      if (opened != KIND_NONE) begin
        if (open_depth >= TB_STACK_DEPTH) begin
          text_err = ERR_OVERFLOW;
        end else begin
          // The first bracket on an empty stack becomes the bottom-most open one.
          if (open_depth == 0) bottom_pos = text_len;
          open_stack[open_depth] = opened;
          open_depth++;
        end
      end else if (closing != KIND_NONE) begin
        // Empty stack or wrong kind on top: the first bad closing bracket.
        if (open_depth == 0 || open_stack[open_depth - 1] != closing) begin
          text_err = ERR_CLOSE;
          bad_pos = text_len;
        end else begin
          open_depth--;
        end
      end
    end

    if (fin) begin
      v.where = '0;
      if (text_err == ERR_CLOSE) begin
        v.status = ST_BAD_CLOSE;
        v.where = bad_pos[WHERE_W-1:0];
      end else if (text_err == ERR_OVERFLOW) begin
        v.status = ST_OVERFLOW;
      end else if (open_depth != 0) begin
        v.status = ST_UNCLOSED;
        v.where = bottom_pos[WHERE_W-1:0];
      end else begin
        v.status = ST_BALANCED;
      end
      expected_verdicts.push_back(v);
      clear_checker();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Text building helpers.
  // ---------------------------------------------------------------------------
  function automatic kind_t random_kind();
    return kind_t'($urandom_range(0, 2));
  endfunction

  function automatic logic [CH_W-1:0] open_byte(input kind_t k);
    case (k)
      KIND_PAREN: return CH_OPEN_PAREN;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      default: return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] close_byte(input kind_t k);
    case (k)
      KIND_PAREN: return CH_CLOSE_PAREN;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      default: return CH_CLOSE_CURLY;
    endcase
  endfunction

  // Any byte that is not a bracket; draws over the full byte range.
  function automatic logic [CH_W-1:0] plain_byte();
    logic [CH_W-1:0] b;
    do begin
      b = CH_W'($urandom_range(0, 255));
    end while (b inside {CH_OPEN_PAREN, CH_OPEN_SQUARE, CH_OPEN_CURLY,
                         CH_CLOSE_PAREN, CH_CLOSE_SQUARE, CH_CLOSE_CURLY});
    return b;
  endfunction

  // Move the draft into the pending queue, last flag on its final byte.
  // A steady text goes out back to back with no idle cycles.
  task automatic send_text(input bit steady);
    text_byte_t item;
    for (int i = 0; i < draft.size(); i++) begin
      item.ch = draft[i];
      item.last = (i == draft.size() - 1);
      item.gap = steady ? 0 : $urandom_range(0, 3);
      pending_bytes.push_back(item);
    end
    queued_items += draft.size();
  endtask

  task automatic send_string(input string s);
    draft.delete();
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    send_text(1'b0);
  endtask

  // Fill the stack to the given depth with random kinds, optionally unwinding it.
  task automatic build_deep(input int unsigned depth, input bit close_all);
    kind_t opened[$];
    kind_t k;
    draft.delete();
    repeat (depth) begin
      k = random_kind();
      opened.push_back(k);
      draft.push_back(open_byte(k));
    end
    if (close_all) begin
      while (opened.size() != 0) draft.push_back(close_byte(opened.pop_back()));
    end
  endtask

  // Random text of the given shape; well-formed shapes track the stack as they go.
  task automatic build_random_text(input text_shape_t shape);
    kind_t opened[$];
    kind_t k;
    int unsigned steps;
    int unsigned cap;
    int unsigned bad_at;
    int unsigned pick;
    draft.delete();
    steps = $urandom_range(1, 30);
    cap = ($urandom_range(0, 5) == 0) ? TB_STACK_DEPTH : $urandom_range(1, 8);
    bad_at = (shape == SHAPE_BAD_CLOSE) ? $urandom_range(0, steps - 1) : steps;
    case (shape)
      SHAPE_DEEP: begin
        build_deep(TB_STACK_DEPTH + $urandom_range(0, 1), $urandom_range(0, 3) != 0);
      end
      SHAPE_NOISE: begin
        // Bracket-heavy garbage, half brackets of any kind, half any byte.
        repeat (steps) begin
          if ($urandom_range(0, 1) == 0) begin
            draft.push_back(CH_W'($urandom_range(0, 255)));
          end else if ($urandom_range(0, 1) == 0) begin
            draft.push_back(open_byte(random_kind()));
          end else begin
            draft.push_back(close_byte(random_kind()));
          end
        end
      end
      default: begin
        for (int unsigned i = 0; i < steps; i++) begin
          pick = $urandom_range(0, 2);
          if (i == bad_at) begin
            // Stray close on an empty stack, or a close of another kind than the top.
            if (opened.size() == 0) begin
              draft.push_back(close_byte(random_kind()));
            end else begin
              draft.push_back(close_byte(kind_t'((int'(opened[$]) + $urandom_range(1, 2)) % 3)));
            end
          end else if (pick == 0 && opened.size() < cap) begin
            k = random_kind();
            opened.push_back(k);
            draft.push_back(open_byte(k));
          end else if (pick == 1 && opened.size() != 0) begin
            draft.push_back(close_byte(opened.pop_back()));
          end else begin
            draft.push_back(plain_byte());
          end
        end
        if (shape == SHAPE_BALANCED) begin
          while (opened.size() != 0) draft.push_back(close_byte(opened.pop_back()));
        end else if (shape == SHAPE_UNCLOSED && opened.size() == 0) begin
          draft.push_back(open_byte(random_kind()));
        end
      end
    endcase
  endtask

  // Hold the sender until every queued byte is taken and every result has come back.
  task automatic wait_for_results();
    do begin
      @(negedge clk);
    end while (pending_bytes.size() != 0 || text_ch.valid || expected_verdicts.size() != 0);
  endtask

  task automatic flag_result(input string what, input verdict_t want,
                             input logic [1:0] got_status, input logic [WHERE_W-1:0] got_where);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s: expected status %0d where %0d, got status %0d where %0d",
               what, want.status, want.where, got_status, got_where);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the head of the pending queue after its idle cycles, hold it
  // until the block takes it.
  // ---------------------------------------------------------------------------
  int unsigned idle_count;

  always @(posedge clk) begin : driver
    text_byte_t next_byte;
    if (rst) begin
      text_ch.valid <= 1'b0;
      text_ch.ch <= '0;
      text_ch.last <= 1'b0;
      idle_count <= 0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        text_ch.valid <= 1'b0;
      end else if (idle_count < pending_bytes[0].gap) begin
        idle_count <= idle_count + 1;
        text_ch.valid <= 1'b0;
      end else begin
        next_byte = pending_bytes.pop_front();
        text_ch.valid <= 1'b1;
        text_ch.ch <= next_byte.ch;
        text_ch.last <= next_byte.last;
        idle_count <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random wait before each result, runs of no waiting, and one long
  // hold-off that backs the block up into its input.
  // ---------------------------------------------------------------------------
  int unsigned rx_wait;
  int unsigned rx_hold;
  int unsigned rx_taken;
  bit rx_hold_done;
  bit rx_steady;

  always @(posedge clk) begin : receiver
    int unsigned draw;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_wait <= 0;
      rx_hold <= 0;
      rx_taken <= 0;
      rx_hold_done <= 1'b0;
      rx_steady <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        rx_taken <= rx_taken + 1;
        if ($urandom_range(0, 15) == 0) rx_steady <= !rx_steady;
      end
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
        result_ch.ready <= (rx_hold == 1);
      end else if (!rx_hold_done && rx_taken >= HOLD_AT) begin
        rx_hold <= HOLD_CYCLES;
        rx_hold_done <= 1'b1;
        result_ch.ready <= 1'b0;
      end else if (result_ch.valid && result_ch.ready) begin
        draw = rx_steady ? 0 : $urandom_range(0, 3);
        rx_wait <= draw;
        result_ch.ready <= (draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        result_ch.ready <= (rx_wait == 1);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest prediction, then feed
  // each taken byte to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst) begin
      clear_checker();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_verdicts.size() == 0) begin
          want = '0;
          flag_result("result with nothing pending", want, result_ch.status, result_ch.where);
        end else begin
          want = expected_verdicts.pop_front();
          if (result_ch.status !== want.status || result_ch.where !== want.where) begin
            flag_result("result mismatch", want, result_ch.status, result_ch.where);
          end
        end
      end
      if (text_ch.valid && text_ch.ready) advance_checker(text_ch.ch, text_ch.last);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed texts, full-stack texts, then random texts.
  // Each phase drains before the next, so the sender also pauses with the block empty.
  // ---------------------------------------------------------------------------
  initial begin
    text_shape_t shape;
    int unsigned pick;
    int unsigned goal;

    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Single-byte texts: plain byte, stray close on an empty stack, lone open.
    draft.delete();
    draft.push_back(8'h00);
    send_text(1'b0);
    send_string(")");
    send_string("(");
    // Every kind opened and closed, nested.
    send_string("([{}])");
    // Each close kind against the wrong open kind.
    send_string("a{]");
    send_string("(]");
    send_string("[}");
    send_string("{)");
    // The stack empties and refills: the bottom-most open moves to the later bracket.
    send_string("(){");
    // Byte extremes around an open bracket.
    draft.delete();
    draft.push_back(8'hFF);
    draft.push_back(CH_OPEN_PAREN);
    draft.push_back(8'h00);
    send_text(1'b0);
    wait_for_results();

    // Full stack: exactly full and unwound, one push too many, full then a bad close,
    // full and left open.
    build_deep(TB_STACK_DEPTH, 1'b1);
    send_text(1'b0);
    build_deep(TB_STACK_DEPTH + 1, 1'b1);
    send_text(1'b0);
    build_deep(TB_STACK_DEPTH, 1'b0);
    draft.push_back(draft[$] == CH_OPEN_PAREN ? CH_CLOSE_CURLY : CH_CLOSE_PAREN);
    draft.push_back(plain_byte());
    send_text(1'b0);
    build_deep(TB_STACK_DEPTH, 1'b0);
    send_text(1'b0);
    wait_for_results();

    // Random texts, mostly well formed with random content, in two batches.
    repeat (2) begin
      goal = queued_items + 320;
      while (queued_items < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) shape = SHAPE_BALANCED;
        else if (pick < 68) shape = SHAPE_BAD_CLOSE;
        else if (pick < 82) shape = SHAPE_UNCLOSED;
        else if (pick < 86) shape = SHAPE_DEEP;
        else shape = SHAPE_NOISE;
        build_random_text(shape);
        send_text($urandom_range(0, 5) == 0);
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
